/* rtl/core/hgvg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgvg_pkg
// Shared constants and types of the hemisphere grid vertex generator: angle
// format, sine polynomial coefficients, register indexes and reset values.
// ----------------------------------------------------------------------------
package hgvg_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int MAX_SLICES   = 255;
    localparam int MAX_RINGS    = 255;
    localparam int HORNER_STEPS = 6;
    localparam int SINE_LAT     = 2 * HORNER_STEPS + 3;
    localparam int DIV_STEPS    = 33;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [33:0] HORNER_INIT = -34'sd3864;
    localparam logic signed [33:0] HORNER_ADD [HORNER_STEPS] = '{
        34'sd172272, -34'sd5026994, 34'sd85569306,
        -34'sd693598668, 34'sd1686629713, 34'sd0
    };

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_LONG   = 2'd1;
    localparam logic [1:0] REG_LAT    = 2'd2;

    localparam logic [15:0] RADIUS_RESET = 16'd1280;
    localparam logic [7:0]  LONG_RESET   = 8'd6;
    localparam logic [7:0]  LAT_RESET    = 8'd4;

    localparam logic [31:0] LONG_RECIP_RESET =
        32'((64'd4294967296 + 64'(LONG_RESET) - 64'd1) / 64'(LONG_RESET));
    localparam logic [31:0] LAT_RECIP_RESET =
        32'((64'd4294967296 + 64'(LAT_RESET) - 64'd1) / 64'(LAT_RESET));

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_LONG = 3'b010,
        DIV_LAT  = 3'b100
    } div_state_t;

    typedef struct packed {
        logic        err;
        logic [15:0] idx_lower;
        logic [15:0] idx_upper;
    } side_t;

endpackage
`default_nettype wire

/* rtl/core/hgvg_sine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hgvg_sine
// Pipelined sine of a turn fraction: quadrant fold, odd polynomial in Q30
// by Horner steps, rounding to Q1.15. Fixed latency, advances on ce.
// ----------------------------------------------------------------------------
module hgvg_sine import hgvg_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   ce,
    input  wire logic [ANGLE_BITS-1:0]  angle,
    output logic signed [15:0]          sine
);

    localparam int CARRY = 2 * HORNER_STEPS + 1;

    logic [31:0] turn;
    logic [30:0] u_fold;
    logic [30:0] u0_reg;
    logic [1:0]  q0_reg;
    logic [61:0] uu;

    logic [30:0] c_u_reg  [CARRY];
    logic [30:0] c_u2_reg [CARRY];
    logic [1:0]  c_q_reg  [CARRY];

    logic signed [33:0] h_s_reg  [HORNER_STEPS];
    logic [62:0]        prod_reg [HORNER_STEPS];
    logic               neg_reg  [HORNER_STEPS];

    logic signed [33:0] s_fin;
    logic [30:0]        s_clamp;
    logic [30:0]        s_round;
    logic [15:0]        mag;
    logic [15:0]        mag_sat;

    assign turn   = {angle, {(32 - ANGLE_BITS){1'b0}}};
    assign u_fold = turn[30] ? (31'h4000_0000 - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
    assign uu     = u0_reg * u0_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            u0_reg      <= u_fold;
            q0_reg      <= turn[31:30];
            c_u_reg[0]  <= u0_reg;
            c_u2_reg[0] <= uu[60:30];
            c_q_reg[0]  <= q0_reg;
        end
    end

    for (genvar m = 0; m < CARRY - 1; m++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (ce) begin
                c_u_reg[m+1]  <= c_u_reg[m];
                c_u2_reg[m+1] <= c_u2_reg[m];
                c_q_reg[m+1]  <= c_q_reg[m];
            end
        end
    end

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
        logic signed [33:0] s_in;
        logic [33:0]        s_mag;
        logic [30:0]        mult_b;
        logic [32:0]        p_shift;
        logic signed [33:0] p_term;

        if (k == 0) begin : g_first
            assign s_in = HORNER_INIT;
        end else begin : g_next
            assign s_in = h_s_reg[k-1];
        end

        assign s_mag   = s_in[33] ? -s_in : s_in;
        assign mult_b  = (k == HORNER_STEPS - 1) ? c_u_reg[2*k] : c_u2_reg[2*k];
        assign p_shift = prod_reg[k][62:30];
        assign p_term  = neg_reg[k] ? -$signed({1'b0, p_shift}) : $signed({1'b0, p_shift});

        always_ff @(posedge aclk) begin
            if (ce) begin
                prod_reg[k] <= s_mag[31:0] * mult_b;
                neg_reg[k]  <= s_in[33];
                h_s_reg[k]  <= p_term + HORNER_ADD[k];
            end
        end
    end

    assign s_fin = h_s_reg[HORNER_STEPS-1];

    always_comb begin
        if (s_fin[33]) begin
            s_clamp = '0;
        end else if (s_fin > Q30_ONE) begin
            s_clamp = Q30_ONE[30:0];
        end else begin
            s_clamp = s_fin[30:0];
        end
    end

    assign s_round = s_clamp + 31'h0000_4000;
    assign mag     = s_round[30:15];
    assign mag_sat = mag[15] ? 16'h7FFF : mag;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sine <= c_q_reg[CARRY-1][1] ? -$signed(mag_sat) : $signed(mag_sat);
        end
    end

endmodule
`default_nettype wire

/* rtl/core/hemisphere_grid_vertex_generator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hemisphere_grid_vertex_generator_core
// Vertex position and triangle-strip indices of one hemisphere grid point.
//
// Channel  Dir  Payload                                        Handshake
// s_       in   tdata: ring[7:0], slice[15:8]                  tvalid/tready
// m_       out  tdata: x, y, z, index_lower, index_upper;      tvalid/tready
//               tuser: range_error
// cfg_     in   cfg_index, cfg_wdata                           cfg_wr_en
//
// One item is taken per cycle while s_tready is high. Each item passes the
// input stage, the angle stage, the four 15-stage sine pipelines and the two
// multiply and round stages that follow them, then the output register.
// After reset the block is ready at once. A write to the slice or ring count
// recomputes both reciprocals, one quotient bit a cycle, and holds s_tready
// low until both are done. A stalled result holds the pipeline only once the
// stage behind the output register is full as well.
// ----------------------------------------------------------------------------
module hemisphere_grid_vertex_generator_core import hgvg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // ring[7:0], slice[15:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // x[16:0], y[33:17], z[50:34],
                                        // index_lower[66:51], index_upper[82:67]
    output logic [0:0]       m_tuser,   // range_error[0]
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int PIPE_DEPTH = SINE_LAT + 6;
    localparam int SIDE_LEN   = SINE_LAT + 5;
    localparam int LAST       = PIPE_DEPTH - 1;

    function automatic logic [7:0] clamp_count(input logic [7:0] v, input logic [7:0] hi);
        logic [7:0] r;
        if (v < 8'd3) begin
            r = 8'd3;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [17:0] round_q15(input logic signed [33:0] p);
        logic [33:0] mag;
        logic [33:0] r;
        mag = p[33] ? -p : p;
        r   = (mag + 34'd16384) >> 15;
        return p[33] ? -$signed(r[17:0]) : $signed(r[17:0]);
    endfunction

    logic [15:0] radius_reg;
    logic [7:0]  long_slices_reg;
    logic [7:0]  lat_slices_reg;
    logic [31:0] long_recip_reg;
    logic [31:0] lat_recip_reg;

    div_state_t  div_state_reg;
    logic        div_start_reg;
    logic [32:0] div_nq_reg;
    logic [7:0]  div_rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [7:0]  div_den;
    logic [8:0]  rem_sh;
    logic        rem_ge;
    logic [8:0]  rem_sub;
    logic [32:0] nq_step;
    logic        div_busy;
    logic        cfg_div_wr;

    logic [PIPE_DEPTH-1:0] v_reg;
    logic        o_valid_reg;
    logic [82:0] o_data_reg;
    logic        o_err_reg;
    logic        out_free;
    logic        ce;
    logic        s_fire;

    logic [7:0]  ring_in;
    logic [7:0]  slice_in;
    logic        err_in;
    logic [7:0]  jm_in;
    logic [7:0]  ring_s1;
    logic [7:0]  jm_s1;
    logic        err_s1;

    logic [ANGLE_BITS+5:0] lat_num;
    logic [ANGLE_BITS+7:0] lon_num;
    logic [ANGLE_BITS+37:0] lat_prod;
    logic [ANGLE_BITS+39:0] lon_prod;
    logic [15:0] il;
    logic [15:0] iu;
    logic [ANGLE_BITS-1:0] lat_reg;
    logic [ANGLE_BITS-1:0] lon_reg;
    side_t       side_reg [SIDE_LEN];

    logic signed [15:0] cos_lat;
    logic signed [15:0] sin_lat;
    logic signed [15:0] cos_lon;
    logic signed [15:0] sin_lon;

    logic signed [33:0] prod_cl_reg;
    logic signed [33:0] prod_y_reg;
    logic signed [15:0] cosn_m1_reg;
    logic signed [15:0] sinn_m1_reg;
    logic signed [17:0] cl_reg;
    logic signed [17:0] y_m2_reg;
    logic signed [15:0] cosn_m2_reg;
    logic signed [15:0] sinn_m2_reg;
    logic signed [33:0] prod_x_reg;
    logic signed [33:0] prod_z_reg;
    logic signed [17:0] y_m3_reg;
    logic signed [17:0] x_reg;
    logic signed [17:0] z_reg;
    logic signed [17:0] y_m4_reg;

    // Configuration and reciprocal divider.
    assign cfg_div_wr = cfg_wr_en && (cfg_index == REG_LONG || cfg_index == REG_LAT);
    assign div_busy   = div_start_reg || (div_state_reg != DIV_IDLE);
    assign div_den    = (div_state_reg == DIV_LAT) ? lat_slices_reg : long_slices_reg;
    assign rem_sh     = {div_rem_reg, div_nq_reg[32]};
    assign rem_ge     = rem_sh >= {1'b0, div_den};
    assign rem_sub    = rem_sh - {1'b0, div_den};
    assign nq_step    = {div_nq_reg[31:0], rem_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= RADIUS_RESET;
            long_slices_reg <= LONG_RESET;
            lat_slices_reg  <= LAT_RESET;
            long_recip_reg  <= LONG_RECIP_RESET;
            lat_recip_reg   <= LAT_RECIP_RESET;
            div_state_reg   <= DIV_IDLE;
            div_start_reg   <= 1'b0;
            div_nq_reg      <= '0;
            div_rem_reg     <= '0;
            div_cnt_reg     <= '0;
        end else begin
            if (div_start_reg) begin
                div_start_reg <= 1'b0;
                div_state_reg <= DIV_LONG;
                div_cnt_reg   <= '0;
                div_rem_reg   <= '0;
                div_nq_reg    <= {1'b1, 32'd0} + 33'(long_slices_reg) - 33'd1;
            end else begin
                case (div_state_reg)
                    DIV_LONG, DIV_LAT: begin
                        div_rem_reg <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
                        div_nq_reg  <= nq_step;
                        div_cnt_reg <= div_cnt_reg + 6'd1;
                        if (div_cnt_reg == 6'(DIV_STEPS - 1)) begin
                            div_cnt_reg <= '0;
                            div_rem_reg <= '0;
                            if (div_state_reg == DIV_LONG) begin
                                long_recip_reg <= nq_step[31:0];
                                div_state_reg  <= DIV_LAT;
                                div_nq_reg     <= {1'b1, 32'd0} + 33'(lat_slices_reg) - 33'd1;
                            end else begin
                                lat_recip_reg <= nq_step[31:0];
                                div_state_reg <= DIV_IDLE;
                            end
                        end
                    end
                    default: begin
                        div_state_reg <= DIV_IDLE;
                    end
                endcase
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_wdata;
                    REG_LONG: begin
                        long_slices_reg <= clamp_count(cfg_wdata[7:0], 8'(MAX_SLICES));
                        div_start_reg   <= 1'b1;
                    end
                    REG_LAT: begin
                        lat_slices_reg <= clamp_count(cfg_wdata[7:0], 8'(MAX_RINGS));
                        div_start_reg  <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Pipeline flow control.
    assign out_free = !o_valid_reg || m_tready;
    assign ce       = !v_reg[LAST] || out_free;
    assign s_tready = ce && !div_busy && !cfg_div_wr;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            if (ce) begin
                v_reg <= {v_reg[PIPE_DEPTH-2:0], s_fire};
            end
            if (out_free) begin
                o_valid_reg <= v_reg[LAST];
            end
        end
    end

    // Input stage: range check and slice wrap.
    assign ring_in  = s_tdata[7:0];
    assign slice_in = s_tdata[15:8];
    assign err_in   = (ring_in > lat_slices_reg) || (slice_in > long_slices_reg);
    assign jm_in    = (slice_in == long_slices_reg) ? 8'd0 : slice_in;

    // Angle numerators; the low parts never overlap the shifted index.
    assign lat_num  = {ring_s1, {(ANGLE_BITS - 9){1'b0}}, lat_slices_reg[7:1]};
    assign lon_num  = {jm_s1, {(ANGLE_BITS - 7){1'b0}}, long_slices_reg[7:1]};
    assign lat_prod = lat_num * lat_recip_reg;
    assign lon_prod = lon_num * long_recip_reg;
    assign il       = 16'(16'(ring_s1) * 16'(long_slices_reg) + 16'(jm_s1));
    assign iu       = il + 16'(long_slices_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ring_s1     <= ring_in;
            jm_s1       <= jm_in;
            err_s1      <= err_in;
            lat_reg     <= lat_prod[ANGLE_BITS+31:32];
            lon_reg     <= lon_prod[ANGLE_BITS+31:32];
            side_reg[0] <= '{err: err_s1, idx_lower: il, idx_upper: iu};
            for (int n = 1; n < SIDE_LEN; n++) begin
                side_reg[n] <= side_reg[n-1];
            end

            prod_cl_reg <= $signed({1'b0, radius_reg}) * cos_lat;
            prod_y_reg  <= $signed({1'b0, radius_reg}) * sin_lat;
            cosn_m1_reg <= cos_lon;
            sinn_m1_reg <= sin_lon;

            cl_reg      <= round_q15(prod_cl_reg);
            y_m2_reg    <= round_q15(prod_y_reg);
            cosn_m2_reg <= cosn_m1_reg;
            sinn_m2_reg <= sinn_m1_reg;

            prod_x_reg  <= cl_reg * cosn_m2_reg;
            prod_z_reg  <= cl_reg * sinn_m2_reg;
            y_m3_reg    <= y_m2_reg;

            x_reg       <= round_q15(prod_x_reg);
            z_reg       <= round_q15(prod_z_reg);
            y_m4_reg    <= y_m3_reg;
        end
        if (out_free) begin
            o_err_reg <= side_reg[SIDE_LEN-1].err;
            if (side_reg[SIDE_LEN-1].err) begin
                o_data_reg <= '0;
            end else begin
                o_data_reg <= {side_reg[SIDE_LEN-1].idx_upper, side_reg[SIDE_LEN-1].idx_lower,
                               z_reg[16:0], y_m4_reg[16:0], x_reg[16:0]};
            end
        end
    end

    hgvg_sine u_cos_lat (
        .aclk  (aclk),
        .ce    (ce),
        .angle (lat_reg + QUARTER_TURN),
        .sine  (cos_lat)
    );

    hgvg_sine u_sin_lat (
        .aclk  (aclk),
        .ce    (ce),
        .angle (lat_reg),
        .sine  (sin_lat)
    );

    hgvg_sine u_cos_lon (
        .aclk  (aclk),
        .ce    (ce),
        .angle (lon_reg + QUARTER_TURN),
        .sine  (cos_lon)
    );

    hgvg_sine u_sin_lon (
        .aclk  (aclk),
        .ce    (ce),
        .angle (lon_reg),
        .sine  (sin_lon)
    );

    assign m_tvalid   = o_valid_reg;
    assign m_tdata    = {5'd0, o_data_reg};
    assign m_tuser[0] = o_err_reg;

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> !s_tready)
        else $error("item accepted while reciprocals are recomputed");

    a_count_write_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_div_wr |=> div_busy)
        else $error("count write did not start the reciprocal divider");

    a_error_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 88'd0)
        else $error("out-of-range item carries a non-zero payload");

    a_tail_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[LAST] && o_valid_reg && !m_tready |=> v_reg[LAST])
        else $error("pipeline tail lost while the output stalled");

endmodule
`default_nettype wire
